>>> src/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Shared types and constants for the expression evaluator.
// ----------------------------------------------------------------------------
`default_nettype none
package iee_pkg;
    localparam int OPND_DEPTH = 64;
    localparam int OPR_DEPTH  = 64;
    localparam int OPND_AW    = $clog2(OPND_DEPTH);
    localparam int OPR_AW     = $clog2(OPR_DEPTH);
    localparam int OPND_CW    = $clog2(OPND_DEPTH + 1);
    localparam int OPR_CW     = $clog2(OPR_DEPTH + 1);

    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_DIV    = 8'h2F;

    localparam logic [31:0] MISSING_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        OP_LPAREN = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIVZERO  = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_MISSING  = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_WAIT_OP,
        S_POP_RHS,
        S_POP_LHS,
        S_CALC,
        S_CALC_WAIT,
        S_PUSH,
        S_FINISH,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        K_OTHER,
        K_RPAREN,
        K_OPER,
        K_LPAREN
    } kind_t;

    typedef struct packed {
        logic capture;
        logic load;
        logic opr_read;
        logic pop_rhs;
        logic pop_lhs;
        logic calc_start;
        logic push_result;
        logic drop_top;
        logic finish;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic  opr_empty;
        logic  last;
        kind_t kind;
        op_t   new_op;
        op_t   top_op;
        logic  calc_done;
    } stat_t;
endpackage
`default_nettype wire

>>> src/iee_ram.sv
// ----------------------------------------------------------------------------
// iee_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

>>> src/iee_alu.sv
// ----------------------------------------------------------------------------
// iee_alu
// Add, subtract, multiply and iterative signed divide on 32-bit values.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_alu
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire op_t         op,
    input  wire logic [31:0] lhs,
    input  wire logic [31:0] rhs,
    output logic             done,
    output logic [31:0]      result,
    output logic             div_zero
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [31:0] res_reg, res_next;
    logic        done_reg, done_next;
    logic        dz_reg, dz_next;
    logic [32:0] trial;
    logic [31:0] rem_sh;
    logic [31:0] alhs, arhs;

    assign alhs   = lhs[31] ? (~lhs + 32'd1) : lhs;
    assign arhs   = rhs[31] ? (~rhs + 32'd1) : rhs;
    assign rem_sh = {rem_reg[30:0], quo_reg[31]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        dz_next   = dz_reg;
        if (start)
        begin
            dz_next = 1'b0;
            case (op)
                OP_ADD:
                begin
                    res_next  = lhs + rhs;
                    done_next = 1'b1;
                end
                OP_SUB:
                begin
                    res_next  = lhs - rhs;
                    done_next = 1'b1;
                end
                OP_MUL:
                begin
                    res_next  = lhs * rhs;
                    done_next = 1'b1;
                end
                default:
                begin
                    if (rhs == 32'd0)
                    begin
                        res_next  = 32'd0;
                        dz_next   = 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        busy_next = 1'b1;
                        cnt_next  = 6'd0;
                        rem_next  = 32'd0;
                        quo_next  = alhs;
                        dvs_next  = arhs;
                        neg_next  = lhs[31] ^ rhs[31];
                    end
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_next = trial[31:0];
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                res_next  = neg_reg ? (~quo_next + 32'd1) : quo_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            dz_reg   <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            dz_reg   <= dz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        res_reg <= res_next;
    end

    assign done     = done_reg;
    assign result   = res_reg;
    assign div_zero = dz_reg;
endmodule
`default_nettype wire

>>> src/iee_datapath.sv
// ----------------------------------------------------------------------------
// iee_datapath
// Stacks, number builder, error status, ALU and result selection.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_datapath
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cmd_t        cmd,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_expr,
    output stat_t            stat,
    output logic [31:0]      value,
    output logic [1:0]       status
);
    logic [OPND_CW-1:0] ocnt_reg, ocnt_next;
    logic [OPR_CW-1:0]  pcnt_reg, pcnt_next;
    logic [31:0]        pend_reg, pend_next;
    logic               act_reg, act_next;
    status_t            err_reg, err_next;
    logic [7:0]         ch_reg;
    logic               last_reg;
    logic [31:0]        rhs_reg;
    op_t                op_reg;

    logic               ond_we;
    logic [OPND_AW-1:0] ond_addr;
    logic [31:0]        ond_wdata, ond_rdata;
    logic               opr_we;
    logic [OPR_AW-1:0]  opr_addr;
    logic [2:0]         opr_wdata, opr_rdata;
    logic [31:0]        alu_res;
    logic               alu_done, alu_dz;

    logic               is_digit, flush;
    kind_t              kind;
    op_t                new_op;
    logic [OPND_CW-1:0] ocnt_m1;
    logic [OPR_CW-1:0]  pcnt_m1;
    logic               rd_empty;
    logic               rhs_empty_reg;
    logic               lhs_empty_reg;

    assign is_digit = (ch_reg >= CH_0) && (ch_reg <= CH_9);
    assign ocnt_m1  = ocnt_reg - OPND_CW'(1);
    assign pcnt_m1  = pcnt_reg - OPR_CW'(1);

    always_comb
    begin
        kind   = K_OTHER;
        new_op = OP_ADD;
        case (ch_reg)
            CH_LPAREN: kind = K_LPAREN;
            CH_RPAREN: kind = K_RPAREN;
            CH_ADD:
            begin
                kind   = K_OPER;
                new_op = OP_ADD;
            end
            CH_SUB:
            begin
                kind   = K_OPER;
                new_op = OP_SUB;
            end
            CH_MUL:
            begin
                kind   = K_OPER;
                new_op = OP_MUL;
            end
            CH_DIV:
            begin
                kind   = K_OPER;
                new_op = OP_DIV;
            end
            default: kind = K_OTHER;
        endcase
    end

    assign flush = act_reg && (cmd.finish || (cmd.load && kind != K_OTHER));

    always_comb
    begin
        ocnt_next = ocnt_reg;
        pcnt_next = pcnt_reg;
        pend_next = pend_reg;
        act_next  = act_reg;
        err_next  = err_reg;
        ond_we    = 1'b0;
        ond_addr  = ocnt_m1[OPND_AW-1:0];
        ond_wdata = pend_reg;
        opr_we    = 1'b0;
        opr_addr  = pcnt_m1[OPR_AW-1:0];
        opr_wdata = 3'(new_op);
        rd_empty  = 1'b0;

        if (cmd.load)
        begin
            if (is_digit)
            begin
                pend_next = (pend_reg << 3) + (pend_reg << 1) + 32'(ch_reg - CH_0);
                act_next  = 1'b1;
            end
            if (flush)
            begin
                pend_next = 32'd0;
                act_next  = 1'b0;
                ond_addr  = ocnt_reg[OPND_AW-1:0];
                if (ocnt_reg < OPND_CW'(OPND_DEPTH))
                begin
                    ond_we    = 1'b1;
                    ocnt_next = ocnt_reg + OPND_CW'(1);
                end
                else if (err_reg == ST_OK)
                begin
                    err_next = ST_OVERFLOW;
                end
            end
        end
        else if (cmd.finish)
        begin
            if (flush)
            begin
                pend_next = 32'd0;
                act_next  = 1'b0;
                ond_addr  = ocnt_reg[OPND_AW-1:0];
                if (ocnt_reg < OPND_CW'(OPND_DEPTH))
                begin
                    ond_we    = 1'b1;
                    ocnt_next = ocnt_reg + OPND_CW'(1);
                end
                else if (err_reg == ST_OK)
                begin
                    err_next = ST_OVERFLOW;
                end
            end
        end
        else if (cmd.pop_rhs || cmd.pop_lhs)
        begin
            if (ocnt_reg == '0)
            begin
                rd_empty = 1'b1;
                if (err_reg == ST_OK)
                begin
                    err_next = ST_MISSING;
                end
            end
            else
            begin
                ocnt_next = ocnt_m1;
            end
        end
        else if (cmd.push_result)
        begin
            ond_addr  = ocnt_reg[OPND_AW-1:0];
            ond_wdata = alu_res;
            if (alu_dz && err_reg == ST_OK)
            begin
                err_next = ST_DIVZERO;
            end
            if (ocnt_reg < OPND_CW'(OPND_DEPTH))
            begin
                ond_we    = 1'b1;
                ocnt_next = ocnt_reg + OPND_CW'(1);
            end
            else if (err_reg == ST_OK && !alu_dz)
            begin
                err_next = ST_OVERFLOW;
            end
        end
        else if (cmd.clear)
        begin
            ocnt_next = '0;
            pcnt_next = '0;
            pend_next = 32'd0;
            act_next  = 1'b0;
            err_next  = ST_OK;
        end

        if (cmd.drop_top)
        begin
            pcnt_next = pcnt_m1;
        end
        else if (cmd.load && (kind == K_OPER || kind == K_LPAREN) && !cmd.opr_read)
        begin
            opr_addr  = pcnt_reg[OPR_AW-1:0];
            opr_wdata = (kind == K_LPAREN) ? 3'(OP_LPAREN) : 3'(new_op);
            if (pcnt_reg < OPR_CW'(OPR_DEPTH))
            begin
                opr_we    = 1'b1;
                pcnt_next = pcnt_reg + OPR_CW'(1);
            end
            else if (err_next == ST_OK)
            begin
                err_next = ST_OVERFLOW;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocnt_reg <= '0;
            pcnt_reg <= '0;
            pend_reg <= 32'd0;
            act_reg  <= 1'b0;
            err_reg  <= ST_OK;
        end
        else
        begin
            ocnt_reg <= ocnt_next;
            pcnt_reg <= pcnt_next;
            pend_reg <= pend_next;
            act_reg  <= act_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            ch_reg   <= char_code;
            last_reg <= end_of_expr;
        end
        if (cmd.drop_top)
        begin
            op_reg <= op_t'(opr_rdata);
        end
        if (cmd.pop_rhs)
        begin
            rhs_empty_reg <= rd_empty;
        end
        if (cmd.pop_lhs)
        begin
            lhs_empty_reg <= rd_empty;
            rhs_reg       <= rhs_empty_reg ? MISSING_VALUE : ond_rdata;
        end
    end

    iee_ram #(.WIDTH(32), .DEPTH(OPND_DEPTH)) u_opnd (
        .clk   (clk),
        .we    (ond_we),
        .addr  (ond_addr),
        .wdata (ond_wdata),
        .rdata (ond_rdata)
    );

    iee_ram #(.WIDTH(3), .DEPTH(OPR_DEPTH)) u_opr (
        .clk   (clk),
        .we    (opr_we),
        .addr  (opr_addr),
        .wdata (opr_wdata),
        .rdata (opr_rdata)
    );

    iee_alu u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.calc_start),
        .op       (op_reg),
        .lhs      (lhs_empty_reg ? MISSING_VALUE : ond_rdata),
        .rhs      (rhs_reg),
        .done     (alu_done),
        .result   (alu_res),
        .div_zero (alu_dz)
    );

    assign stat.opr_empty = (pcnt_reg == '0);
    assign stat.last      = last_reg;
    assign stat.kind      = kind;
    assign stat.new_op    = new_op;
    assign stat.top_op    = op_t'(opr_rdata);
    assign stat.calc_done = alu_done;
    assign value          = (ocnt_reg == '0) ? MISSING_VALUE : ond_rdata;
    assign status         = (ocnt_reg == '0 && err_reg == ST_OK) ? 2'(ST_MISSING)
                                                                  : 2'(err_reg);
endmodule
`default_nettype wire

>>> src/iee_ctrl.sv
// ----------------------------------------------------------------------------
// iee_ctrl
// Sequencer for item handling, operator unwinding and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_ctrl
    import iee_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  wire logic  out_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);
    state_t state_reg, state_next;
    logic   fin_reg, fin_next;
    logic   top_muldiv, new_muldiv, stop;

    assign top_muldiv = (stat.top_op == OP_MUL) || (stat.top_op == OP_DIV);
    assign new_muldiv = (stat.new_op == OP_MUL) || (stat.new_op == OP_DIV);

    always_comb
    begin
        stop = 1'b0;
        if (fin_reg)
        begin
            stop = 1'b0;
        end
        else if (stat.kind == K_RPAREN)
        begin
            stop = (stat.top_op == OP_LPAREN);
        end
        else
        begin
            stop = (stat.top_op == OP_LPAREN) || (!top_muldiv && new_muldiv);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECIDE;
                    fin_next   = 1'b0;
                end
            end
            S_DECIDE:
            begin
                if (fin_reg)
                begin
                    state_next = stat.opr_empty ? S_OUT : S_WAIT_OP;
                end
                else if ((stat.kind == K_RPAREN || stat.kind == K_OPER) && !stat.opr_empty)
                begin
                    state_next = S_WAIT_OP;
                end
                else if (stat.last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_WAIT_OP:
            begin
                if (stop)
                begin
                    if (stat.kind == K_OPER)
                    begin
                        state_next = stat.last ? S_FINISH : S_IDLE;
                    end
                    else
                    begin
                        state_next = stat.last ? S_FINISH : S_IDLE;
                    end
                end
                else if (stat.top_op == OP_LPAREN)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_POP_RHS;
                end
            end
            S_POP_RHS: state_next = S_POP_LHS;
            S_POP_LHS: state_next = S_CALC;
            S_CALC:    state_next = S_CALC_WAIT;
            S_CALC_WAIT:
            begin
                if (stat.calc_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:    state_next = S_DECIDE;
            S_FINISH:
            begin
                state_next = S_DECIDE;
                fin_next   = 1'b1;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        in_stall  = (state_reg != S_IDLE);
        out_valid = (state_reg == S_OUT) && (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = in_valid;
            end
            S_DECIDE:
            begin
                if (!fin_reg)
                begin
                    cmd.load     = 1'b1;
                    cmd.opr_read = (stat.kind == K_OPER) && !stat.opr_empty;
                end
            end
            S_WAIT_OP:
            begin
                if (stop)
                begin
                    if (stat.kind == K_RPAREN)
                    begin
                        cmd.drop_top = 1'b1;
                    end
                    else if (stat.kind == K_OPER)
                    begin
                        cmd.load = 1'b1;
                    end
                end
                else
                begin
                    cmd.drop_top = 1'b1;
                end
            end
            S_POP_RHS:  cmd.pop_rhs = 1'b1;
            S_POP_LHS:  cmd.pop_lhs = 1'b1;
            S_CALC:     cmd.calc_start = 1'b1;
            S_PUSH:     cmd.push_result = 1'b1;
            S_FINISH:   cmd.finish = 1'b1;
            S_OUT:      cmd.clear = !out_stall;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end
endmodule
`default_nettype wire

>>> src/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Two-stack evaluator of integer infix expressions, one character per item.
// ----------------------------------------------------------------------------
// One character is taken per item; each operator applied from the stack
// goes through a top read, two stack RAM reads, the ALU and a push, and a
// divide also runs through the bit-serial divider. The final character
// unwinds all stacked operators and presents value/status until taken; both
// stacks live in single-port RAMs, which set the step count of each unwind.
`default_nettype none
module infix_expression_evaluator
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_expr,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic signed [31:0] value,
    output logic [1:0]       status
);
    cmd_t        cmd;
    stat_t       stat;
    logic [31:0] val_u;

    iee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    iee_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .char_code   (char_code),
        .end_of_expr (end_of_expr),
        .stat        (stat),
        .value       (val_u),
        .status      (status)
    );

    assign value = signed'(val_u);
endmodule
`default_nettype wire

>>> tb/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker
// Watches the character and result channels of the expression evaluator,
// keeps its own two-stack model of each expression, and compares every
// result with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none
module iee_checker
    import iee_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  char_code,
    input  wire logic        end_of_expr,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] value,
    input  wire logic [1:0]  status,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] opnd_stk [OPND_DEPTH];
    op_t         opr_stk  [OPR_DEPTH];
    int          opnd_cnt;
    int          opr_cnt;
    logic [31:0] number;
    logic        num_open;
    status_t     err;
    logic [31:0] want_value [$];
    status_t     want_status [$];

    function automatic void note(status_t s);
        if (err == ST_OK)
            err = s;
    endfunction

    function automatic void push_opnd(logic [31:0] v);
        if (opnd_cnt < OPND_DEPTH)
        begin
            opnd_stk[opnd_cnt] = v;
            opnd_cnt++;
        end
        else
            note(ST_OVERFLOW);
    endfunction

    function automatic logic [31:0] pop_opnd();
        if (opnd_cnt == 0)
        begin
            note(ST_MISSING);
            return MISSING_VALUE;
        end
        opnd_cnt--;
        return opnd_stk[opnd_cnt];
    endfunction

    function automatic void push_opr(op_t o);
        if (opr_cnt < OPR_DEPTH)
        begin
            opr_stk[opr_cnt] = o;
            opr_cnt++;
        end
        else
            note(ST_OVERFLOW);
    endfunction

    function automatic void reduce_top();
        op_t         o;
        logic [31:0] rhs;
        logic [31:0] lhs;
        logic [31:0] r;
        opr_cnt--;
        o = opr_stk[opr_cnt];
        if (o == OP_LPAREN)
            return;
        rhs = pop_opnd();
        lhs = pop_opnd();
        case (o)
            OP_ADD: r = lhs + rhs;
            OP_SUB: r = lhs - rhs;
            OP_MUL: r = lhs * rhs;
            default:
            begin
                if (rhs == 32'd0)
                begin
                    note(ST_DIVZERO);
                    r = 32'd0;
                end
                else if (lhs == 32'h8000_0000 && rhs == 32'hFFFF_FFFF)
                    r = 32'h8000_0000;
                else
                    r = $signed(lhs) / $signed(rhs);
            end
        endcase
        push_opnd(r);
    endfunction

    function automatic void close_number();
        if (num_open)
        begin
            push_opnd(number);
            number = 32'd0;
            num_open = 1'b0;
        end
    endfunction

    function automatic void clear_expr();
        opnd_cnt = 0;
        opr_cnt = 0;
        number = 32'd0;
        num_open = 1'b0;
        err = ST_OK;
    endfunction

    function automatic void eval_char(logic [7:0] c, logic last);
        op_t         o;
        logic        is_op;
        logic [31:0] v;
        is_op = 1'b1;
        o = OP_ADD;
        if (c >= CH_0 && c <= CH_9)
        begin
            number = number * 32'd10 + 32'(c - CH_0);
            num_open = 1'b1;
            is_op = 1'b0;
        end
        else if (c == CH_LPAREN)
        begin
            close_number();
            push_opr(OP_LPAREN);
            is_op = 1'b0;
        end
        else if (c == CH_RPAREN)
        begin
            close_number();
            while (opr_cnt > 0 && opr_stk[opr_cnt-1] != OP_LPAREN)
                reduce_top();
            if (opr_cnt > 0)
                opr_cnt--;
            is_op = 1'b0;
        end
        else if (c == CH_ADD) o = OP_ADD;
        else if (c == CH_SUB) o = OP_SUB;
        else if (c == CH_MUL) o = OP_MUL;
        else if (c == CH_DIV) o = OP_DIV;
        else is_op = 1'b0;
        if (is_op)
        begin
            close_number();
            while (opr_cnt > 0)
            begin
                if (opr_stk[opr_cnt-1] == OP_LPAREN)
                    break;
                if (opr_stk[opr_cnt-1] inside {OP_ADD, OP_SUB} && o inside {OP_MUL, OP_DIV})
                    break;
                reduce_top();
            end
            push_opr(o);
        end
        if (!last)
            return;
        close_number();
        while (opr_cnt > 0)
            reduce_top();
        if (opnd_cnt == 0)
        begin
            note(ST_MISSING);
            v = MISSING_VALUE;
        end
        else
            v = opnd_stk[opnd_cnt-1];
        want_value.push_back(v);
        want_status.push_back(err);
        clear_expr();
    endfunction

    assign pending = want_value.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_expr();
            fail_count <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                eval_char(char_code, end_of_expr);
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (want_value.size() == 0)
                begin
                    $error("unexpected result value=%0d status=%0d", $signed(value), status);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (value !== want_value[0] || status !== want_status[0])
                    begin
                        if (value !== want_value[0])
                            $error("value: expected %0d actual %0d",
                                   $signed(want_value[0]), $signed(value));
                        if (status !== want_status[0])
                            $error("status: expected %0d actual %0d",
                                   want_status[0], status);
                        fail_count <= fail_count + 1;
                    end
                    void'(want_value.pop_front());
                    void'(want_status.pop_front());
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Feeds the expression evaluator directed and random expressions, character
// by character, with random gaps and result-side stalls; the checker predicts
// and compares every result and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    import iee_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [7:0]  char_code = 0;
    logic        end_of_expr = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [31:0] value;
    logic [1:0]  status;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          cycles = 0;
    int          chars_sent = 0;
    int          exprs_sent = 0;
    bit          quiet = 0;

    always #10 clk = ~clk;

    infix_expression_evaluator u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .end_of_expr(end_of_expr), .out_valid(out_valid),
        .out_stall(out_stall), .value(value), .status(status)
    );

    iee_checker u_chk (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .char_code(char_code), .end_of_expr(end_of_expr), .out_valid(out_valid),
        .out_stall(out_stall), .value(value), .status(status),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result-side stall bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        while (1)
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 4);
                out_stall <= 1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 0;
        end
    end

    task automatic send(logic [7:0] c, logic last);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 4);
            in_valid <= 0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1;
        char_code <= c;
        end_of_expr <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        chars_sent++;
        if (last)
            exprs_sent++;
    endtask

    task automatic send_str(string s);
        for (int i = 0; i < s.len(); i++)
            send(s[i], i == s.len() - 1);
    endtask

    task automatic send_number(int digits);
        for (int i = 0; i < digits; i++)
            send(CH_0 + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    function automatic logic [7:0] pick_op();
        case ($urandom_range(0, 3))
            0: return CH_ADD;
            1: return CH_SUB;
            2: return CH_MUL;
            default: return CH_DIV;
        endcase
    endfunction

    // well-formed expression with random content; the final character is an
    // operand digit or a ')', marked last unless the last term closed every '('
    task automatic send_expr(int terms, int max_depth);
        int depth;
        depth = 0;
        for (int t = 0; t < terms; t++)
        begin
            while (depth < max_depth && $urandom_range(0, 3) == 0)
            begin
                send(CH_LPAREN, 0);
                depth++;
            end
            if (t == terms - 1 && depth == 0)
            begin
                send_number($urandom_range(0, 2));
                send(CH_0 + ($urandom_range(0, 4) == 0 ? 8'd0 : 8'($urandom_range(1, 9))),
                     1'b1);
            end
            else
            begin
                send_number($urandom_range(1, 3));
                while (depth > 0 && $urandom_range(0, 2) == 0)
                begin
                    send(CH_RPAREN, 0);
                    depth--;
                end
                if (t < terms - 1)
                    send(pick_op(), 0);
            end
        end
        while (depth > 0)
        begin
            send(CH_RPAREN, depth == 1);
            depth--;
        end
    endtask

    initial
    begin
        int k;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_str("12+34*5");
        send_str("(7-9)/2");
        send_str("8/0");
        send_str("6*(3+");
        send_str("*");
        send_str(")");
        send_str("2147483647+1");
        send_str("99999999999");
        send_str("2147483648/4294967295");
        send_str("(((5)))x");
        send(8'hFF, 0);
        send(8'h00, 0);
        send(8'h20, 1);
        for (int i = 0; i < 65; i++)
            send(CH_LPAREN, 0);
        send(CH_0 + 8'd1, 1);
        for (int i = 0; i < 65; i++)
        begin
            send(CH_0 + 8'd1, 0);
            send(CH_LPAREN, 0);
        end
        send(CH_RPAREN, 1);

        while (chars_sent < 1800)
        begin
            k = $urandom_range(0, 9);
            if (k < 7)
                send_expr($urandom_range(1, 6), 3);
            else if (k < 9)
            begin
                repeat ($urandom_range(1, 6))
                    send(8'($urandom_range(0, 255)), 1'b0);
                send(8'($urandom_range(0, 255)), 1'b1);
            end
            else
                send(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
        quiet = 1;
        repeat (20)
            send_expr($urandom_range(1, 4), 2);
        in_valid <= 0;
        end_of_expr <= 0;

        k = 0;
        while (pending != 0 && k < 100000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (400) @(posedge clk);
        $display("Sent %0d characters in %0d expressions; %0d results checked.",
                 chars_sent, exprs_sent, results_seen);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
src/iee_pkg.sv
src/iee_ram.sv
src/iee_alu.sv
src/iee_datapath.sv
src/iee_ctrl.sv
src/infix_expression_evaluator.sv
tb/iee_checker.sv
tb/tb_top.sv
